// ===== design/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and helper functions of the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int COORD_FRAC_BITS_DEF  = 8;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH            = 16;
  localparam int OUT_MAX              = 32767;
  localparam logic [63:0] EPS_Q40     = 64'd1099512;

  // Smallest squared cross product length, in units of 2^-4F, that is not
  // below the squared epsilon floor.
  function automatic logic [127:0] eps_limit(input int frac);
    logic [63:0]  e2;
    logic [127:0] w;
    int           k;
    e2 = EPS_Q40 * EPS_Q40;
    k  = 80 - 4 * frac;
    w  = '0;
    if (k <= 0) begin
      w = {64'd0, e2} << (-k);
    end else if (k >= 64) begin
      w = 128'd1;
    end else begin
      w = {64'd0, (e2 + ((64'd1 << k) - 64'd1)) >> k};
    end
    return w;
  endfunction

  // Largest magnitude that an output component may take.
  function automatic int out_lim(input int nfb);
    int l;
    l = (nfb >= 15) ? OUT_MAX : (1 << nfb);
    return l;
  endfunction

endpackage

// ===== design/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// Three-stage cross product of the edge vectors, giving sign and magnitude.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_neg,
  output logic [2*COORD_WIDTH+1:0]      out_mag [3]
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = 2 * DW;
  localparam int PW = MW + 1;

  logic [2:0] v_r;
  logic [2:0] en;
  logic signed [DW-1:0]   u_r [3];
  logic signed [DW-1:0]   w_r [3];
  logic signed [2*DW-1:0] m_r [6];
  logic signed [PW-1:0]   p   [3];
  logic [PW-1:0]          pa  [3];
  logic [2:0]             neg_r;
  logic [MW-1:0]          mag_r [3];

  assign en[2]    = ~v_r[2] | out_ready;
  assign en[1]    = ~v_r[1] | en[2];
  assign en[0]    = ~v_r[0] | en[1];
  assign in_ready = en[0];
  assign out_valid = v_r[2];
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;

  always_comb begin
    p[0] = PW'(m_r[0]) - PW'(m_r[1]);
    p[1] = PW'(m_r[2]) - PW'(m_r[3]);
    p[2] = PW'(m_r[4]) - PW'(m_r[5]);
    for (int i = 0; i < 3; i++) begin
      pa[i] = p[i][PW-1] ? PW'(-p[i]) : PW'(p[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
    if (en[0] && in_valid) begin
      u_r[0] <= DW'(bx) - DW'(ax);
      u_r[1] <= DW'(by_coord) - DW'(ay);
      u_r[2] <= DW'(bz) - DW'(az);
      w_r[0] <= DW'(cx) - DW'(ax);
      w_r[1] <= DW'(cy) - DW'(ay);
      w_r[2] <= DW'(cz) - DW'(az);
    end
    if (en[1] && v_r[0]) begin
      m_r[0] <= u_r[1] * w_r[2];
      m_r[1] <= u_r[2] * w_r[1];
      m_r[2] <= u_r[2] * w_r[0];
      m_r[3] <= u_r[0] * w_r[2];
      m_r[4] <= u_r[0] * w_r[1];
      m_r[5] <= u_r[1] * w_r[0];
    end
    if (en[2] && v_r[1]) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= p[i][PW-1];
        mag_r[i] <= pa[i][MW-1:0];
      end
    end
  end

endmodule

// ===== design/tfn_nsq.sv =====
// ----------------------------------------------------------------------------
// tfn_nsq
// Three-stage squared length of the cross product, epsilon test and the
// starting remainders of the normalizing search.
// ----------------------------------------------------------------------------
module tfn_nsq import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  localparam int MW = 2 * COORD_WIDTH + 2,
  localparam int SW = 2 * MW + 2,
  localparam int CW = SW + 2 * NORMAL_FRAC_BITS + 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_neg,
  input  logic [MW-1:0] in_mag [3],
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_neg,
  output logic          out_floored,
  output logic [SW-1:0] out_s,
  output logic [CW-1:0] out_r [3]
);

  localparam int SQW = 2 * MW;
  localparam int HL  = (MW + 1) / 2;
  localparam int HH  = MW - HL;
  localparam int LW  = (SW > 128) ? SW : 128;
  localparam logic [127:0] EPS_LIMIT = eps_limit(COORD_FRAC_BITS);

  logic [2:0] v_r;
  logic [2:0] en;
  logic [2:0] neg0_r, neg1_r, neg2_r;
  logic [2*HH-1:0]  hh_r [3];
  logic [HH+HL-1:0] hl_r [3];
  logic [2*HL-1:0]  ll_r [3];
  logic [SQW-1:0]   sq_r [3];
  logic [SW-1:0]    s_nxt;
  logic [SW-1:0]    s_r;
  logic             fl_r;
  logic [CW-1:0]    r_r [3];

  assign en[2]       = ~v_r[2] | out_ready;
  assign en[1]       = ~v_r[1] | en[2];
  assign en[0]       = ~v_r[0] | en[1];
  assign in_ready    = en[0];
  assign out_valid   = v_r[2];
  assign out_neg     = neg2_r;
  assign out_floored = fl_r;
  assign out_s       = s_r;
  assign out_r       = r_r;

  assign s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
    if (en[0] && in_valid) begin
      neg0_r <= in_neg;
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= (2*HH)'(in_mag[i][MW-1:HL]) * (2*HH)'(in_mag[i][MW-1:HL]);
        hl_r[i] <= (HH+HL)'(in_mag[i][MW-1:HL]) * (HH+HL)'(in_mag[i][HL-1:0]);
        ll_r[i] <= (2*HL)'(in_mag[i][HL-1:0]) * (2*HL)'(in_mag[i][HL-1:0]);
      end
    end
    if (en[1] && v_r[0]) begin
      neg1_r <= neg0_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (SQW'(hh_r[i]) << (2 * HL)) + (SQW'(hl_r[i]) << (HL + 1))
                   + SQW'(ll_r[i]);
      end
    end
    if (en[2] && v_r[1]) begin
      neg2_r <= neg1_r;
      s_r    <= s_nxt;
      fl_r   <= LW'(s_nxt) < LW'(EPS_LIMIT);
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= CW'(sq_r[i]) << (2 * NORMAL_FRAC_BITS);
      end
    end
  end

endmodule

// ===== design/tfn_div_step.sv =====
// ----------------------------------------------------------------------------
// tfn_div_step
// One stage of the normalizing search: settles one quotient bit per lane.
// ----------------------------------------------------------------------------
module tfn_div_step import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  parameter int BIT_POS          = 0,
  localparam int SW = 4 * COORD_WIDTH + 6,
  localparam int CW = SW + 2 * NORMAL_FRAC_BITS + 4,
  localparam int QW = NORMAL_FRAC_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_neg,
  input  logic          in_floored,
  input  logic [SW-1:0] in_s,
  input  logic [CW-1:0] in_r [3],
  input  logic [CW-1:0] in_y [3],
  input  logic [QW-1:0] in_q [3],
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_neg,
  output logic          out_floored,
  output logic [SW-1:0] out_s,
  output logic [CW-1:0] out_r [3],
  output logic [CW-1:0] out_y [3],
  output logic [QW-1:0] out_q [3]
);

  logic          v_r;
  logic          en;
  logic [2:0]    neg_r;
  logic          fl_r;
  logic [SW-1:0] s_r;
  logic [CW-1:0] r_r [3];
  logic [CW-1:0] y_r [3];
  logic [QW-1:0] q_r [3];
  logic [CW-1:0] d   [3];

  assign en          = ~v_r | out_ready;
  assign in_ready    = en;
  assign out_valid   = v_r;
  assign out_neg     = neg_r;
  assign out_floored = fl_r;
  assign out_s       = s_r;
  assign out_r       = r_r;
  assign out_y       = y_r;
  assign out_q       = q_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = (in_y[i] << (BIT_POS + 1)) + (CW'(in_s) << (2 * BIT_POS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en && in_valid) begin
      neg_r <= in_neg;
      fl_r  <= in_floored;
      s_r   <= in_s;
      for (int i = 0; i < 3; i++) begin
        if (d[i] <= in_r[i]) begin
          r_r[i] <= in_r[i] - d[i];
          y_r[i] <= in_y[i] + (CW'(in_s) << BIT_POS);
          q_r[i] <= in_q[i] | (QW'(1) << BIT_POS);
        end else begin
          r_r[i] <= in_r[i];
          y_r[i] <= in_y[i];
          q_r[i] <= in_q[i];
        end
      end
    end
  end

endmodule

// ===== design/tfn_round.sv =====
// ----------------------------------------------------------------------------
// tfn_round
// Final rounding, clamping and sign of the normal, zero for a floored length; holds the output register.
// ----------------------------------------------------------------------------
module tfn_round import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
  localparam int SW = 4 * COORD_WIDTH + 6,
  localparam int CW = SW + 2 * NORMAL_FRAC_BITS + 4,
  localparam int QW = NORMAL_FRAC_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_neg,
  input  logic                        in_floored,
  input  logic [SW-1:0]               in_s,
  input  logic [CW-1:0]               in_r [3],
  input  logic [CW-1:0]               in_y [3],
  input  logic [QW-1:0]               in_q [3],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] out_n [3],
  output logic                        out_floored
);

  localparam int LIM = out_lim(NORMAL_FRAC_BITS);

  logic                 v_r;
  logic                 en;
  logic                 fl_r;
  logic [OUT_WIDTH-1:0] n_r  [3];
  logic [QW:0]          qr   [3];
  logic [OUT_WIDTH-1:0] qc   [3];
  logic [OUT_WIDTH-1:0] n_nxt [3];

  assign en          = ~v_r | out_ready;
  assign in_ready    = en;
  assign out_valid   = v_r;
  assign out_floored = fl_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (((CW + 2)'(in_y[i]) << 2) + (CW + 2)'(in_s) <= ((CW + 2)'(in_r[i]) << 2)) begin
        qr[i] = (QW + 1)'(in_q[i]) + (QW + 1)'(1);
      end else begin
        qr[i] = (QW + 1)'(in_q[i]);
      end
      if (32'(qr[i]) > 32'(LIM)) begin
        qc[i] = OUT_WIDTH'(LIM);
      end else begin
        qc[i] = OUT_WIDTH'(qr[i]);
      end
      if (in_floored) begin
        n_nxt[i] = '0;
      end else if (in_neg[i]) begin
        n_nxt[i] = OUT_WIDTH'(-qc[i]);
      end else begin
        n_nxt[i] = qc[i];
      end
      out_n[i] = $signed(n_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en && in_valid) begin
      fl_r <= in_floored;
      n_r  <= n_nxt;
    end
  end

endmodule

// ===== design/triangle_face_normal.sv =====
// Throughput: one triangle per cycle unless out_ready stalls; the pipeline is
// three cross product stages, three squared length stages, one stage per quotient
// bit and one rounding stage.
// Each stage holds its request until the next stage frees, so a stall loses nothing.
// Reset: synchronous, active low, clears all stage valid bits.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, Q7.8 vertices in, Q1.14 normal out.
// ----------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_az,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by_coord,
  input  logic signed [COORD_WIDTH-1:0] in_bz,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  input  logic signed [COORD_WIDTH-1:0] in_cz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_WIDTH-1:0]   out_nx,
  output logic signed [OUT_WIDTH-1:0]   out_ny,
  output logic signed [OUT_WIDTH-1:0]   out_nz,
  output logic                          out_length_floored
);

  localparam int MW = 2 * COORD_WIDTH + 2;
  localparam int SW = 2 * MW + 2;
  localparam int CW = SW + 2 * NORMAL_FRAC_BITS + 4;
  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int NS = NORMAL_FRAC_BITS + 1;

  logic          x_valid, x_ready;
  logic [2:0]    x_neg;
  logic [MW-1:0] x_mag [3];

  logic          st_valid [NS+1];
  logic          st_ready [NS+1];
  logic [2:0]    st_neg   [NS+1];
  logic          st_fl    [NS+1];
  logic [SW-1:0] st_s     [NS+1];
  logic [CW-1:0] st_r     [NS+1][3];
  logic [CW-1:0] st_y     [NS+1][3];
  logic [QW-1:0] st_q     [NS+1][3];

  logic signed [OUT_WIDTH-1:0] n [3];

  tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .ax(in_ax), .ay(in_ay), .az(in_az),
    .bx(in_bx), .by_coord(in_by_coord), .bz(in_bz),
    .cx(in_cx), .cy(in_cy), .cz(in_cz),
    .out_valid(x_valid), .out_ready(x_ready),
    .out_neg(x_neg), .out_mag(x_mag)
  );

  tfn_nsq #(
    .COORD_WIDTH(COORD_WIDTH),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_nsq (
    .clk, .rst_n,
    .in_valid(x_valid), .in_ready(x_ready),
    .in_neg(x_neg), .in_mag(x_mag),
    .out_valid(st_valid[0]), .out_ready(st_ready[0]),
    .out_neg(st_neg[0]), .out_floored(st_fl[0]),
    .out_s(st_s[0]), .out_r(st_r[0])
  );

  for (genvar l = 0; l < 3; l++) begin : g_seed
    assign st_y[0][l] = '0;
    assign st_q[0][l] = '0;
  end

  for (genvar g = 0; g < NS; g++) begin : g_step
    tfn_div_step #(
      .COORD_WIDTH(COORD_WIDTH),
      .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
      .BIT_POS(NORMAL_FRAC_BITS - g)
    ) u_step (
      .clk, .rst_n,
      .in_valid(st_valid[g]), .in_ready(st_ready[g]),
      .in_neg(st_neg[g]), .in_floored(st_fl[g]), .in_s(st_s[g]),
      .in_r(st_r[g]), .in_y(st_y[g]), .in_q(st_q[g]),
      .out_valid(st_valid[g+1]), .out_ready(st_ready[g+1]),
      .out_neg(st_neg[g+1]), .out_floored(st_fl[g+1]), .out_s(st_s[g+1]),
      .out_r(st_r[g+1]), .out_y(st_y[g+1]), .out_q(st_q[g+1])
    );
  end

  tfn_round #(
    .COORD_WIDTH(COORD_WIDTH),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_round (
    .clk, .rst_n,
    .in_valid(st_valid[NS]), .in_ready(st_ready[NS]),
    .in_neg(st_neg[NS]), .in_floored(st_fl[NS]), .in_s(st_s[NS]),
    .in_r(st_r[NS]), .in_y(st_y[NS]), .in_q(st_q[NS]),
    .out_valid, .out_ready,
    .out_n(n), .out_floored(out_length_floored)
  );

  assign out_nx = n[0];
  assign out_ny = n[1];
  assign out_nz = n[2];

endmodule

// ===== design/tfn_checker.sv =====
// ----------------------------------------------------------------------------
// tfn_props
// Port-level checks of the triangle face normal unit, bound to the top level.
// ----------------------------------------------------------------------------
module tfn_props import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [OUT_WIDTH-1:0] out_nx,
  input logic signed [OUT_WIDTH-1:0] out_ny,
  input logic signed [OUT_WIDTH-1:0] out_nz,
  input logic                        out_length_floored
);

  localparam int LIM = out_lim(NORMAL_FRAC_BITS);

  // A held result keeps its payload until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nx) && $stable(out_ny)
      && $stable(out_nz) && $stable(out_length_floored))
    else $error("result changed while stalled");

  // A floored length gives the zero vector.
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_floored |-> out_nx == 0 && out_ny == 0 && out_nz == 0)
    else $error("floored length with nonzero normal");

  // Every component stays within the clamp.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_nx) <= LIM && 32'(out_nx) >= -LIM
      && 32'(out_ny) <= LIM && 32'(out_ny) >= -LIM
      && 32'(out_nz) <= LIM && 32'(out_nz) >= -LIM)
    else $error("normal component out of range");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_face_normal tfn_props #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tfn_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_nx, .out_ny, .out_nz, .out_length_floored
);

// ===== sim/tfn_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfn_checker
// Watches both channels of the face normal unit, computes the unit normal of
// every accepted triangle and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module tfn_checker import tfn_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [15:0]          in_ax,
  input  logic signed [15:0]          in_ay,
  input  logic signed [15:0]          in_az,
  input  logic signed [15:0]          in_bx,
  input  logic signed [15:0]          in_by_coord,
  input  logic signed [15:0]          in_bz,
  input  logic signed [15:0]          in_cx,
  input  logic signed [15:0]          in_cy,
  input  logic signed [15:0]          in_cz,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [OUT_WIDTH-1:0] out_nx,
  input  logic signed [OUT_WIDTH-1:0] out_ny,
  input  logic signed [OUT_WIDTH-1:0] out_nz,
  input  logic                        out_length_floored,
  output int                          fail_count,
  output int                          pending_normals
);

  localparam int NFB = NORMAL_FRAC_BITS_DEF;
  localparam int CFB = COORD_FRAC_BITS_DEF;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] nx;
    logic signed [OUT_WIDTH-1:0] ny;
    logic signed [OUT_WIDTH-1:0] nz;
    logic                        floored;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic signed [OUT_WIDTH-1:0] unit_component(longint p,
                                                                logic [127:0] len_sq);
    logic [63:0]  a;
    logic [127:0] t;
    logic [127:0] k;
    logic [63:0]  q;
    logic [63:0]  tr;
    logic [63:0]  lim;
    a = (p < 0) ? -p : p;
    t = ({64'd0, a} * {64'd0, a}) << (2 * NFB + 2);
    q = 0;
    for (int b = NFB; b >= 0; b--) begin
      tr = q | (64'd1 << b);
      k  = {64'd0, 2 * tr} * {64'd0, 2 * tr};
      if (len_sq * k <= t) q = tr;
    end
    k = {64'd0, 2 * q + 1} * {64'd0, 2 * q + 1};
    if (len_sq * k <= t) q = q + 1;
    lim = (NFB >= 15) ? 64'd32767 : (64'd1 << NFB);
    if (q > lim) q = lim;
    return (p < 0) ? -q[OUT_WIDTH-1:0] : q[OUT_WIDTH-1:0];
  endfunction

  function automatic normal_t face_normal(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz,
                                          longint cx, longint cy, longint cz);
    normal_t      r;
    longint       ux, uy, uz, vx, vy, vz, px, py, pz;
    logic [63:0]  mx, my, mz;
    logic [63:0]  e2;
    logic [127:0] len_sq;
    logic [127:0] floor_sq;
    int           sh;
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    px = uy * vz - uz * vy;
    py = uz * vx - ux * vz;
    pz = ux * vy - uy * vx;
    mx = (px < 0) ? -px : px;
    my = (py < 0) ? -py : py;
    mz = (pz < 0) ? -pz : pz;
    len_sq = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
           + {64'd0, mz} * {64'd0, mz};
    e2 = EPS_Q40 * EPS_Q40;
    sh = 80 - 4 * CFB;
    if (sh <= 0) floor_sq = {64'd0, e2} << (-sh);
    else if (sh >= 64) floor_sq = 128'd1;
    else floor_sq = {64'd0, (e2 + ((64'd1 << sh) - 64'd1)) >> sh};
    r.floored = (len_sq < floor_sq);
    r.nx = '0; r.ny = '0; r.nz = '0;
    if (!r.floored) begin
      r.nx = unit_component(px, len_sq);
      r.ny = unit_component(py, len_sq);
      r.nz = unit_component(pz, len_sq);
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("tfn_checker: %0t %s mismatch, got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count      = 0;
    pending_normals = 0;
  end

  always @(posedge clk) begin
    normal_t e;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_normals.push_back(face_normal(in_ax, in_ay, in_az, in_bx, in_by_coord,
                                               in_bz, in_cx, in_cy, in_cz));
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = expected_normals.pop_front();
          if (out_nx !== e.nx) report("nx", out_nx, e.nx);
          if (out_ny !== e.ny) report("ny", out_ny, e.ny);
          if (out_nz !== e.nz) report("nz", out_nz, e.nz);
          if (out_length_floored !== e.floored)
            report("length_floored", out_length_floored, e.floored);
        end
      end
      pending_normals = expected_normals.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random triangles into the face normal unit with random
// gaps and output stalls; the checker predicts and compares every normal.
// ----------------------------------------------------------------------------
module testbench import tfn_pkg::*; ();

  localparam int RANDOM_TRIANGLES = 930;
  localparam int IDLE_LIMIT       = 2000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [15:0]          in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz;
  logic signed [15:0]          in_cx, in_cy, in_cz;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [OUT_WIDTH-1:0] out_nx, out_ny, out_nz;
  logic                        out_length_floored;
  int                          fail_count;
  int                          pending_normals;
  int                          idle_cycles;
  logic                        no_stall_phase;

  triangle_face_normal u_top (.*);

  tfn_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_length(logic busy);
    int r;
    r = $urandom_range(99);
    if (busy) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk);
      if (n > 0) begin
        n--;
      end else begin
        out_ready <= (gap_length(no_stall_phase) == 0) ? 1'b1 : 1'b0;
        if (!out_ready) n = $urandom_range(2);
        if ($urandom_range(99) < 5) n = gap_length(1'b0);
      end
    end
  end

  task automatic send_triangle(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                               logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    int g;
    in_ax <= ax; in_ay <= ay; in_az <= az;
    in_bx <= bx; in_by_coord <= by; in_bz <= bz;
    in_cx <= cx; in_cy <= cy; in_cz <= cz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    g = gap_length(no_stall_phase);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] near(logic [15:0] base);
    int w;
    w = $urandom_range(12);
    return 16'(base + ($urandom_range((1 << w) - 1) - (1 << (w - 1 < 0 ? 0 : w - 1))));
  endfunction

  initial begin
    logic [15:0] v[9];
    int          mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    idle_cycles = 0;
    no_stall_phase = 1'b0;
    {in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz, in_cx, in_cy, in_cz} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h7fff);
    send_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256);
    send_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0);
    send_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0);
    send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
    send_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000);
    send_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h8000, 16'h8000);
    send_triangle(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h8000, 16'h8000, 16'h7fff);
    send_triangle(16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h0000, 16'h8000, 16'h8000);
    send_triangle(16'hffff, 16'hffff, 16'hffff, 0, 16'hffff, 16'hffff,
                  16'hffff, 0, 16'hffff);
    send_triangle(100, 200, 300, 101, 200, 300, 100, 201, 301);
    send_triangle(0, 0, 0, 3, 4, 0, 16'hfffc, 3, 5);
    send_triangle(16'h1234, 16'h4321, 16'h8765, 16'h1234, 16'h4321, 16'h8765,
                  16'h1111, 16'h2222, 16'h3333);
    send_triangle(0, 0, 0, 16'h7fff, 0, 0, 0, 1, 0);

    for (int i = 0; i < RANDOM_TRIANGLES; i++) begin
      no_stall_phase = (i >= 400 && i < 520);
      mode = $urandom_range(99);
      for (int j = 0; j < 9; j++) v[j] = 16'($urandom);
      if (mode < 35) begin
        for (int j = 3; j < 9; j++) v[j] = near(v[j % 3]);
      end else if (mode < 45) begin
        for (int j = 3; j < 6; j++) v[j] = 16'(v[j % 3] + $urandom_range(3) - 1);
        for (int j = 6; j < 9; j++) v[j] = v[j % 3];
      end else if (mode < 55) begin
        for (int j = 0; j < 3; j++) begin
          v[j + 6] = 16'(v[j] + 2 * (v[j + 3] - v[j]));
        end
      end else if (mode < 65) begin
        for (int j = 0; j < 9; j++)
          if ($urandom_range(1)) v[j] = $urandom_range(1) ? 16'h7fff : 16'h8000;
      end
      send_triangle(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    end
    in_valid <= 1'b0;
    no_stall_phase = 1'b0;
    @(posedge clk);

    while (pending_normals != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_normals == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
